@@ hw/rtl/mgts_pkg.sv @@
// ----------------------------------------------------------------------------
// mgts_pkg: shared types and constants of the minor GC transaction sequencer
// Holds the op, phase and error codes, the payload structs of both channels
// and the saturating counter add.
// ----------------------------------------------------------------------------
`default_nettype none

package mgts_pkg;

	// Width of byte and object counters
	localparam int BYTE_BITS = 40;
	// Width of the diagnostic fields of a result
	localparam int DIAG_W = 40;
	// Width of a saturating sum before the clamp
	localparam int SUM_W = ((BYTE_BITS > 32) ? BYTE_BITS : 32) + 1;

	localparam logic [BYTE_BITS-1:0] BYTE_MASK = {BYTE_BITS{1'b1}};

	// Operation codes
	localparam logic [2:0] OP_INIT     = 3'd0;
	localparam logic [2:0] OP_BEGIN    = 3'd1;
	localparam logic [2:0] OP_EVACUATE = 3'd2;
	localparam logic [2:0] OP_REWRITE  = 3'd3;
	localparam logic [2:0] OP_VERIFY   = 3'd4;
	localparam logic [2:0] OP_RESUME   = 3'd5;
	localparam logic [2:0] OP_ABORT    = 3'd6;
	localparam logic [2:0] OP_UNDEF    = 3'd7;

	// Transaction phases
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_EVACUATE = 3'd1;
	localparam logic [2:0] PH_REWRITE  = 3'd2;
	localparam logic [2:0] PH_VERIFY   = 3'd3;
	localparam logic [2:0] PH_RESUME   = 3'd4;
	localparam logic [2:0] PH_COMPLETE = 3'd5;
	localparam logic [2:0] PH_ABORTED  = 3'd6;

	// Error codes
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_BAD_ARG      = 4'd1;
	localparam logic [3:0] ERR_NOT_STOPPED  = 4'd2;
	localparam logic [3:0] ERR_NO_ROOTS     = 4'd3;
	localparam logic [3:0] ERR_BAD_PHASE    = 4'd4;
	localparam logic [3:0] ERR_BAD_REGION   = 4'd5;
	localparam logic [3:0] ERR_SPACE_FULL   = 4'd6;
	localparam logic [3:0] ERR_UNRESOLVED   = 4'd7;
	localparam logic [3:0] ERR_INCONSISTENT = 4'd8;

	// One event
	typedef struct packed {
		logic [2:0]           op;
		logic [31:0]          region_total;
		logic [BYTE_BITS-1:0] space_bytes;
		logic [31:0]          budget;
		logic                 stopped_in;
		logic                 roots_ready;
		logic [BYTE_BITS-1:0] live_bytes;
		logic [31:0]          object_total;
		logic [31:0]          ref_count;
	} req_t;

	// One result
	typedef struct packed {
		logic                 ok;
		logic [3:0]           error_code;
		logic [DIAG_W-1:0]    expected_value;
		logic [DIAG_W-1:0]    actual_value;
		logic [2:0]           phase_out;
		logic [31:0]          cursor_out;
		logic                 boundary_ok;
		logic                 can_resume;
		logic                 stopped_out;
		logic [BYTE_BITS-1:0] used_bytes_out;
		logic [BYTE_BITS-1:0] evacuated_out;
		logic [BYTE_BITS-1:0] promoted_out;
	} rsp_t;

	// Add two zero-extended counts and clamp at all ones
	function automatic logic [BYTE_BITS-1:0] sat_add(
		input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b
	);
		logic [SUM_W-1:0] s;
		s = a + b;
		if (s > SUM_W'(BYTE_MASK)) begin
			return BYTE_MASK;
		end
		return s[BYTE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mgts_if.sv @@
// ----------------------------------------------------------------------------
// mgts_if: valid/ready channels of the minor GC transaction sequencer
// Event channel and result channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface mgts_req_if;
	logic          valid;
	logic          ready;
	mgts_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mgts_rsp_if;
	logic          valid;
	logic          ready;
	mgts_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/minor_gc_transaction_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// minor_gc_transaction_sequencer_core: minor collection transaction sequencer
// Walks one minor collection through its phases, one op per event, and
// answers each event with status, a dense error code and diagnostics.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event (op plus arguments) per transfer; rsp carries
//   exactly one result per event, in event order.
//   An accepted event is held in an input register; once the result
//   register is free or its result moves on, the phase and counter
//   registers are updated and the result is written to the output
//   register. The block takes one event per cycle while rsp is not
//   stalled: the single pass of compares, one 40-bit subtract and the
//   saturating adds sits between the input and output registers.
//   When rsp is stalled the output register holds its result, the input
//   register holds the next event, and req.ready drops until the result
//   moves on.
//   arst_n clears both valid flags and returns the transaction to idle with
//   all counters zero and the boundary consistent. No clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none

module minor_gc_transaction_sequencer_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mgts_req_if.sink    req,
	mgts_rsp_if.source  rsp
);
	import mgts_pkg::*;

	// Input register
	logic                 valid_s1;
	req_t                 item_s1;
	// Result register
	logic                 valid_s2;
	rsp_t                 result_s2;

	// Transaction state
	logic [2:0]           phase_q;
	logic [31:0]          region_limit_q;
	logic [31:0]          region_cursor_q;
	logic [BYTE_BITS-1:0] space_limit_q;
	logic [BYTE_BITS-1:0] space_used_q;
	logic [BYTE_BITS-1:0] evacuated_q;
	logic [BYTE_BITS-1:0] promoted_q;
	logic [31:0]          rewritten_q;
	logic [31:0]          unresolved_q;
	logic                 held_q;
	logic                 traced_q;
	logic                 consistent_q;

	// Next state and result
	logic [2:0]           phase_d;
	logic [31:0]          region_limit_d;
	logic [31:0]          region_cursor_d;
	logic [BYTE_BITS-1:0] space_limit_d;
	logic [BYTE_BITS-1:0] space_used_d;
	logic [BYTE_BITS-1:0] evacuated_d;
	logic [BYTE_BITS-1:0] promoted_d;
	logic [31:0]          rewritten_d;
	logic [31:0]          unresolved_d;
	logic                 held_d;
	logic                 traced_d;
	logic                 consistent_d;
	logic [3:0]           code;
	logic [DIAG_W-1:0]    exp_v;
	logic [DIAG_W-1:0]    act_v;
	logic [BYTE_BITS-1:0] free_bytes;
	logic                 resume_ok;
	rsp_t                 result;

	logic                 advance;

	// Move the held event on when the result register is free
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = valid_s2;
	assign rsp.data  = result_s2;

	// Hold the accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	// Resolve the event against the current phase and counters
	always_comb begin
		phase_d         = phase_q;
		region_limit_d  = region_limit_q;
		region_cursor_d = region_cursor_q;
		space_limit_d   = space_limit_q;
		space_used_d    = space_used_q;
		evacuated_d     = evacuated_q;
		promoted_d      = promoted_q;
		rewritten_d     = rewritten_q;
		unresolved_d    = unresolved_q;
		held_d          = held_q;
		traced_d        = traced_q;
		consistent_d    = consistent_q;
		code            = ERR_NONE;
		exp_v           = '0;
		act_v           = '0;
		free_bytes      = (space_limit_q >= space_used_q) ?
			(space_limit_q - space_used_q) : '0;

		unique case (item_s1.op)
			OP_INIT: begin
				phase_d         = PH_IDLE;
				region_limit_d  = '0;
				region_cursor_d = '0;
				space_limit_d   = '0;
				space_used_d    = '0;
				evacuated_d     = '0;
				promoted_d      = '0;
				rewritten_d     = '0;
				unresolved_d    = '0;
				held_d          = 1'b0;
				traced_d        = 1'b0;
				consistent_d    = 1'b1;
			end
			OP_BEGIN: begin
				priority if (item_s1.region_total == '0 || item_s1.space_bytes == '0 ||
						item_s1.budget == '0) begin
					code  = ERR_BAD_ARG;
					exp_v = DIAG_W'(1);
				end else if (!item_s1.stopped_in) begin
					code  = ERR_NOT_STOPPED;
					exp_v = DIAG_W'(1);
				end else if (!item_s1.roots_ready) begin
					code  = ERR_NO_ROOTS;
					exp_v = DIAG_W'(1);
				end else if (phase_q != PH_IDLE && phase_q != PH_COMPLETE &&
						phase_q != PH_ABORTED) begin
					code  = ERR_BAD_PHASE;
					act_v = DIAG_W'(phase_q);
				end else begin
					phase_d         = PH_EVACUATE;
					region_limit_d  = item_s1.region_total;
					region_cursor_d = '0;
					space_limit_d   = item_s1.space_bytes;
					space_used_d    = '0;
					evacuated_d     = '0;
					promoted_d      = '0;
					rewritten_d     = '0;
					unresolved_d    = '0;
					held_d          = 1'b1;
					traced_d        = 1'b1;
					consistent_d    = 1'b0;
				end
			end
			OP_EVACUATE: begin
				priority if (phase_q != PH_EVACUATE || !held_q || !traced_q) begin
					code  = ERR_BAD_PHASE;
					exp_v = DIAG_W'(PH_EVACUATE);
					act_v = DIAG_W'(phase_q);
				end else if (region_cursor_q >= region_limit_q ||
						item_s1.object_total == '0) begin
					code  = ERR_BAD_REGION;
					exp_v = DIAG_W'(region_limit_q);
					act_v = DIAG_W'(region_cursor_q);
				end else if (item_s1.live_bytes > free_bytes) begin
					code         = ERR_SPACE_FULL;
					exp_v        = DIAG_W'(free_bytes);
					act_v        = DIAG_W'(item_s1.live_bytes);
					consistent_d = 1'b0;
				end else begin
					space_used_d    = sat_add(SUM_W'(space_used_q), SUM_W'(item_s1.live_bytes));
					evacuated_d     = sat_add(SUM_W'(evacuated_q), SUM_W'(item_s1.live_bytes));
					promoted_d      = sat_add(SUM_W'(promoted_q), SUM_W'(item_s1.object_total));
					region_cursor_d = region_cursor_q + 32'd1;
					consistent_d    = 1'b0;
					if (region_cursor_d == region_limit_q) begin
						phase_d = PH_REWRITE;
					end
				end
			end
			OP_REWRITE: begin
				if (phase_q != PH_REWRITE || !held_q) begin
					code  = ERR_BAD_PHASE;
					exp_v = DIAG_W'(PH_REWRITE);
					act_v = DIAG_W'(phase_q);
				end else begin
					rewritten_d  = item_s1.ref_count;
					phase_d      = PH_VERIFY;
					consistent_d = 1'b0;
				end
			end
			OP_VERIFY: begin
				if (phase_q != PH_VERIFY || !held_q) begin
					code  = ERR_BAD_PHASE;
					exp_v = DIAG_W'(PH_VERIFY);
					act_v = DIAG_W'(phase_q);
				end else begin
					unresolved_d = item_s1.ref_count;
					if (item_s1.ref_count != '0) begin
						code         = ERR_UNRESOLVED;
						act_v        = DIAG_W'(item_s1.ref_count);
						consistent_d = 1'b0;
					end else begin
						phase_d      = PH_RESUME;
						consistent_d = 1'b1;
					end
				end
			end
			OP_RESUME: begin
				if (!(phase_q == PH_RESUME && held_q && traced_q && unresolved_q == '0 &&
						consistent_q)) begin
					code  = ERR_INCONSISTENT;
					exp_v = DIAG_W'(PH_RESUME);
					act_v = DIAG_W'(phase_q);
				end else begin
					held_d       = 1'b0;
					phase_d      = PH_COMPLETE;
					consistent_d = 1'b1;
				end
			end
			OP_ABORT: begin
				if (phase_q < PH_EVACUATE || phase_q > PH_RESUME) begin
					code  = ERR_BAD_PHASE;
					exp_v = DIAG_W'(PH_EVACUATE);
					act_v = DIAG_W'(phase_q);
				end else begin
					phase_d      = PH_ABORTED;
					consistent_d = 1'b1;
				end
			end
			OP_UNDEF: begin
				code  = ERR_BAD_ARG;
				exp_v = DIAG_W'(OP_ABORT);
				act_v = DIAG_W'(OP_UNDEF);
			end
		endcase

		resume_ok = (phase_d == PH_RESUME) && held_d && traced_d &&
			(unresolved_d == '0) && consistent_d;

		result.ok             = (code == ERR_NONE);
		result.error_code     = code;
		result.expected_value = exp_v;
		result.actual_value   = act_v;
		result.phase_out      = phase_d;
		result.cursor_out     = region_cursor_d;
		result.boundary_ok    = consistent_d;
		result.can_resume     = resume_ok;
		result.stopped_out    = held_d;
		result.used_bytes_out = space_used_d;
		result.evacuated_out  = evacuated_d;
		result.promoted_out   = promoted_d;
	end

	// Advance the transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			region_limit_q  <= '0;
			region_cursor_q <= '0;
			space_limit_q   <= '0;
			space_used_q    <= '0;
			evacuated_q     <= '0;
			promoted_q      <= '0;
			rewritten_q     <= '0;
			unresolved_q    <= '0;
			held_q          <= 1'b0;
			traced_q        <= 1'b0;
			consistent_q    <= 1'b1;
		end else if (advance) begin
			phase_q         <= phase_d;
			region_limit_q  <= region_limit_d;
			region_cursor_q <= region_cursor_d;
			space_limit_q   <= space_limit_d;
			space_used_q    <= space_used_d;
			evacuated_q     <= evacuated_d;
			promoted_q      <= promoted_d;
			rewritten_q     <= rewritten_d;
			unresolved_q    <= unresolved_d;
			held_q          <= held_d;
			traced_q        <= traced_d;
			consistent_q    <= consistent_d;
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// A result is ok exactly when it carries no error code
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.ok == (rsp.data.error_code == ERR_NONE)))
		else $error("ok flag disagrees with error code");

	// Resume readiness implies the resume phase, held mutators and a clean boundary
	a_can_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.can_resume) |->
		(rsp.data.phase_out == PH_RESUME && rsp.data.stopped_out && rsp.data.boundary_ok))
		else $error("can_resume without its preconditions");

	// The region cursor never passes the region limit
	a_cursor_limit: assert property (@(posedge clk) disable iff (!arst_n)
		region_cursor_q <= region_limit_q)
		else $error("region cursor beyond limit");

	// Used to-space never exceeds the to-space limit
	a_space_limit: assert property (@(posedge clk) disable iff (!arst_n)
		space_used_q <= space_limit_q)
		else $error("to-space overcommitted");

	// Init returns the transaction to idle with a cleared cursor
	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.op == OP_INIT) |=>
		(phase_q == PH_IDLE && region_cursor_q == '0 && consistent_q && !held_q))
		else $error("init did not clear the transaction");

	// A stalled result register keeps the event waiting
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp.ready) |-> !advance)
		else $error("event processed while result stalled");

endmodule

`default_nettype wire
